FILE: hw/rtl/ansi_pkg.sv
// ----------------------------------------------------------------------------
// ANSI color escape parser package
// Shared coordinate width, parser state codes, register indexes, character
// codes, reset values, the result word type and the SGR color table.
// ----------------------------------------------------------------------------
`default_nettype none

package ansi_pkg;

  localparam int COORD_BITS = 16;

  // Parser state codes.
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ESC    = 2'd1;
  localparam logic [1:0] ST_CSI    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG_COLOR    = 2'd2;

  // Result actions.
  localparam logic ACT_PRINT = 1'b0;
  localparam logic ACT_ERASE = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] COLOR_WHITE    = 32'hFFFF_FFFF;
  localparam logic [31:0] COLOR_BG_RESET = 32'hFF00_0000;
  localparam logic [7:0]  CELL_W_RESET   = 8'd8;
  localparam logic [7:0]  CELL_H_RESET   = 8'd16;

  typedef struct packed {
    logic                  action;
    logic [7:0]            char_out;
    logic [31:0]           color;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  last;
  } res_t;

  // Maps an SGR parameter to a foreground color; unlisted codes give white.
  function automatic logic [31:0] sgr_color(input logic [7:0] n);
    logic [31:0] col;
    begin
      unique case (n)
        8'd30:   col = 32'hFF11_1111;
        8'd31:   col = 32'hFFFF_5555;
        8'd32:   col = 32'hFF55_FF55;
        8'd33:   col = 32'hFFFF_FF55;
        8'd34:   col = 32'hFF55_55FF;
        8'd35:   col = 32'hFFFF_55FF;
        8'd36:   col = 32'hFF55_FFFF;
        8'd90:   col = 32'hFF88_8888;
        8'd91:   col = 32'hFFFF_8888;
        8'd92:   col = 32'hFF88_FF88;
        8'd93:   col = 32'hFFFF_FF88;
        8'd94:   col = 32'hFF88_88FF;
        8'd95:   col = 32'hFFFF_88FF;
        8'd96:   col = 32'hFF88_FFFF;
        default: col = COLOR_WHITE;
      endcase
      return col;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ansi_color_escape_parser_unit.sv
// ----------------------------------------------------------------------------
// ANSI color escape parser unit
// Filters SGR color sequences out of a byte stream and turns backspace into
// an erase-cell command when the cursor lies at least one cell width in.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle and registers its results in a two-word
// output buffer. Most bytes give one result word or none, so with the output
// side always ready the unit sustains one byte per clock. An ESC followed by
// a byte other than '[' gives two words (ESC, then the byte); the next byte
// waits while both words are in the buffer. The input is taken whenever the
// buffer will be empty after the current cycle.
// Configuration writes are taken at any time (cfg_ready is always high).
`default_nettype none

module ansi_color_escape_parser_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input byte channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_char_in,
  input  wire logic [ansi_pkg::COORD_BITS-1:0] in_cursor_x_in,
  input  wire logic [ansi_pkg::COORD_BITS-1:0] in_cursor_y_in,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_action,
  output logic [7:0]                          out_char_out,
  output logic [31:0]                         out_color,
  output logic [ansi_pkg::COORD_BITS-1:0]     out_pos_x,
  output logic [ansi_pkg::COORD_BITS-1:0]     out_pos_y,
  output logic                                out_last,
  // Configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int CB = ansi_pkg::COORD_BITS;

  // Configuration registers
  logic [7:0]  cell_w_r;
  logic [7:0]  cell_h_r;
  logic [31:0] bg_color_r;

  // Parser state
  logic [1:0]  state_r,  state_nxt;
  logic [7:0]  param_r,  param_nxt;
  logic [31:0] fg_r,     fg_nxt;

  // Output buffer: q0_r is the head word
  ansi_pkg::res_t q0_r, q1_r;
  ansi_pkg::res_t r0, r1;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [1:0]     n_res;

  logic           in_acc, out_acc, cfg_acc;
  logic [11:0]    param_sum;
  logic           is_digit;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid & out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_acc    = in_valid & in_ready;

  assign out_action   = q0_r.action;
  assign out_char_out = q0_r.char_out;
  assign out_color    = q0_r.color;
  assign out_pos_x    = q0_r.pos_x;
  assign out_pos_y    = q0_r.pos_y;
  assign out_last     = q0_r.last;

  assign is_digit  = (in_char_in >= ansi_pkg::CH_ZERO) && (in_char_in <= ansi_pkg::CH_NINE);
  // Digits '0'..'9' carry their value in the low nibble.
  assign param_sum = ({4'd0, param_r} * 12'd10) + {8'd0, in_char_in[3:0]};

  always_comb begin
    state_nxt = state_r;
    param_nxt = param_r;
    fg_nxt    = fg_r;
    n_res     = 2'd0;
    r0 = '{action: ansi_pkg::ACT_PRINT, char_out: in_char_in, color: fg_r,
           pos_x: in_cursor_x_in, pos_y: in_cursor_y_in, last: 1'b1};
    r1 = r0;
    unique case (state_r)
      ansi_pkg::ST_ESC: begin
        if (in_char_in == ansi_pkg::CH_LBRK) begin
          state_nxt = ansi_pkg::ST_CSI;
          param_nxt = 8'd0;
        end else begin
          state_nxt   = ansi_pkg::ST_NORMAL;
          n_res       = 2'd2;
          r0.char_out = ansi_pkg::CH_ESC;
          r0.last     = 1'b0;
        end
      end
      ansi_pkg::ST_CSI: begin
        priority if (is_digit) begin
          param_nxt = (param_sum > 12'd255) ? 8'd255 : param_sum[7:0];
        end else if (in_char_in == ansi_pkg::CH_M) begin
          fg_nxt    = ansi_pkg::sgr_color(param_r);
          param_nxt = 8'd0;
          state_nxt = ansi_pkg::ST_NORMAL;
        end else if (in_char_in == ansi_pkg::CH_SEMI) begin
          fg_nxt    = ansi_pkg::sgr_color(param_r);
          param_nxt = 8'd0;
        end else begin
          param_nxt = 8'd0;
          state_nxt = ansi_pkg::ST_NORMAL;
        end
      end
      default: begin
        // Normal state; the unused code behaves the same.
        state_nxt = ansi_pkg::ST_NORMAL;
        priority if (in_char_in == ansi_pkg::CH_ESC) begin
          state_nxt = ansi_pkg::ST_ESC;
        end else if (in_char_in == ansi_pkg::CH_BS) begin
          if (in_cursor_x_in >= {{(CB-8){1'b0}}, cell_w_r}) begin
            n_res     = 2'd1;
            r0.action = ansi_pkg::ACT_ERASE;
            r0.color  = bg_color_r;
            r0.pos_x  = in_cursor_x_in - {{(CB-8){1'b0}}, cell_w_r};
          end
        end else begin
          n_res = 2'd1;
        end
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = n_res;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= 2'd0;
      state_r    <= ansi_pkg::ST_NORMAL;
      param_r    <= 8'd0;
      fg_r       <= ansi_pkg::COLOR_WHITE;
      cell_w_r   <= ansi_pkg::CELL_W_RESET;
      cell_h_r   <= ansi_pkg::CELL_H_RESET;
      bg_color_r <= ansi_pkg::COLOR_BG_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
        param_r <= param_nxt;
        fg_r    <= fg_nxt;
      end
      if (cfg_acc) begin
        unique case (cfg_index)
          ansi_pkg::REG_CELL_WIDTH:  cell_w_r   <= cfg_data[7:0];
          ansi_pkg::REG_CELL_HEIGHT: cell_h_r   <= cfg_data[7:0];
          ansi_pkg::REG_BG_COLOR:    bg_color_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result words; the buffer is always drained when a new byte is taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0_r <= r0;
      q1_r <= r1;
    end else if (out_acc) begin
      q0_r <= q1_r;
    end
  end

  // The cell height is stored, but no result uses it.
  logic cell_h_unused;
  assign cell_h_unused = ^cell_h_r;

  // Assertions
  a_two_words_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!q0_r.last && q1_r.last && q0_r.char_out == ansi_pkg::CH_ESC))
    else $error("two-word result not ordered as ESC then byte");

  a_erase_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ansi_pkg::ACT_ERASE) |->
      (out_char_out == ansi_pkg::CH_BS && out_last))
    else $error("erase word malformed");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && n_res != 2'd0) |=> out_valid)
    else $error("accepted byte with results did not produce a word");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != 2'd3) && (cnt_r != 2'd3))
    else $error("parser state or buffer count out of range");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the ANSI color escape parser unit
// Feeds a byte stream with cursor positions through the parser: directed
// escape sequences and backspaces first, then random traffic made mostly of
// well-formed color sequences. Each phase uses different cell and background
// settings. Both handshake sides stall at random, and every result word is
// checked against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ansi_pkg::*;

  typedef struct {
    logic [7:0]            ch;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } char_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_char_in = '0;
  logic [COORD_BITS-1:0] in_cursor_x_in = '0;
  logic [COORD_BITS-1:0] in_cursor_y_in = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_action;
  logic [7:0]            out_char_out;
  logic [31:0]           out_color;
  logic [COORD_BITS-1:0] out_pos_x;
  logic [COORD_BITS-1:0] out_pos_y;
  logic                  out_last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  // Characters waiting to be driven, and screen commands still to arrive.
  char_item_t pending_chars[$];
  res_t       screen_cmds_due[$];
  char_item_t next_char;

  // Parser model state and its copy of the registers.
  logic [1:0]  parser_state = ST_NORMAL;
  logic [7:0]  sgr_param = '0;
  logic [31:0] fg_color = COLOR_WHITE;
  logic [7:0]  cell_w = CELL_W_RESET;
  logic [7:0]  cell_h = CELL_H_RESET;
  logic [31:0] bg_color = COLOR_BG_RESET;

  logic        in_accepted_q = 1'b0;
  logic        out_accepted_q = 1'b0;
  int          in_hold = 0;
  int          out_hold = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  int          err_count = 0;
  int          stim_items = 0;
  logic [7:0]  stim_cw = CELL_W_RESET;

  ansi_color_escape_parser_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .in_cursor_x_in (in_cursor_x_in),
    .in_cursor_y_in (in_cursor_y_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_char_out   (out_char_out),
    .out_color      (out_color),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  function automatic logic [31:0] sgr_fg_color(input logic [7:0] code);
    logic [31:0] c;
    case (code)
      8'd30:   c = 32'hFF11_1111;
      8'd31:   c = 32'hFFFF_5555;
      8'd32:   c = 32'hFF55_FF55;
      8'd33:   c = 32'hFFFF_FF55;
      8'd34:   c = 32'hFF55_55FF;
      8'd35:   c = 32'hFFFF_55FF;
      8'd36:   c = 32'hFF55_FFFF;
      8'd90:   c = 32'hFF88_8888;
      8'd91:   c = 32'hFFFF_8888;
      8'd92:   c = 32'hFF88_FF88;
      8'd93:   c = 32'hFFFF_FF88;
      8'd94:   c = 32'hFF88_88FF;
      8'd95:   c = 32'hFFFF_88FF;
      8'd96:   c = 32'hFF88_FFFF;
      default: c = COLOR_WHITE;
    endcase
    return c;
  endfunction

  function automatic res_t make_word(input logic act, input logic [7:0] ch,
                                     input logic [31:0] col,
                                     input logic [COORD_BITS-1:0] x,
                                     input logic [COORD_BITS-1:0] y,
                                     input logic lst);
    res_t w;
    w.action   = act;
    w.char_out = ch;
    w.color    = col;
    w.pos_x    = x;
    w.pos_y    = y;
    w.last     = lst;
    return w;
  endfunction

  // Advances the parser model by one byte and queues the commands it causes.
  task automatic parse_char(input logic [7:0] c, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    int acc;
    case (parser_state)
      ST_ESC: begin
        if (c == CH_LBRK) begin
          parser_state = ST_CSI;
          sgr_param = '0;
        end else begin
          parser_state = ST_NORMAL;
          screen_cmds_due.push_back(make_word(ACT_PRINT, CH_ESC, fg_color, x, y, 1'b0));
          screen_cmds_due.push_back(make_word(ACT_PRINT, c, fg_color, x, y, 1'b1));
        end
      end
      ST_CSI: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          acc = int'(sgr_param) * 10 + int'(c) - int'(CH_ZERO);
          sgr_param = (acc > 255) ? 8'd255 : acc[7:0];
        end else if (c == CH_M || c == CH_SEMI) begin
          fg_color = sgr_fg_color(sgr_param);
          sgr_param = '0;
          if (c == CH_M) parser_state = ST_NORMAL;
        end else begin
          // Anything else aborts the sequence silently.
          sgr_param = '0;
          parser_state = ST_NORMAL;
        end
      end
      default: begin
        parser_state = ST_NORMAL;
        if (c == CH_ESC) begin
          parser_state = ST_ESC;
        end else if (c == CH_BS) begin
          if (x >= COORD_BITS'(cell_w))
            screen_cmds_due.push_back(make_word(ACT_ERASE, CH_BS, bg_color,
                                                x - COORD_BITS'(cell_w), y, 1'b1));
        end else begin
          screen_cmds_due.push_back(make_word(ACT_PRINT, c, fg_color, x, y, 1'b1));
        end
      end
    endcase
  endtask

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Driver: new bytes and ready changes go out on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_accepted_q) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          next_char = pending_chars.pop_front();
          in_valid       <= 1'b1;
          in_char_in     <= next_char.ch;
          in_cursor_x_in <= next_char.x;
          in_cursor_y_in <= next_char.y;
          in_hold = draw_wait(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_accepted_q) out_hold = draw_wait(out_burst);
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: everything is sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_accepted_q  <= 1'b0;
      out_accepted_q <= 1'b0;
    end else begin
      in_accepted_q  <= in_valid && in_ready;
      out_accepted_q <= out_valid && out_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CELL_WIDTH:  cell_w = cfg_data[7:0];
          REG_CELL_HEIGHT: cell_h = cfg_data[7:0];
          REG_BG_COLOR:    bg_color = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_char(in_char_in, in_cursor_x_in, in_cursor_y_in);
      if (out_valid && out_ready) begin
        if (screen_cmds_due.size() == 0) begin
          report_mismatch("result word with none expected", 32'(out_char_out), 0);
        end else begin
          res_t want;
          want = screen_cmds_due.pop_front();
          if (out_action !== want.action)
            report_mismatch("action", 32'(out_action), 32'(want.action));
          if (out_char_out !== want.char_out)
            report_mismatch("char_out", 32'(out_char_out), 32'(want.char_out));
          if (out_color !== want.color)
            report_mismatch("color", out_color, want.color);
          if (out_pos_x !== want.pos_x)
            report_mismatch("pos_x", 32'(out_pos_x), 32'(want.pos_x));
          if (out_pos_y !== want.pos_y)
            report_mismatch("pos_y", 32'(out_pos_y), 32'(want.pos_y));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
    end
  end

  task automatic push_at(input logic [7:0] c, input logic [COORD_BITS-1:0] x,
                         input logic [COORD_BITS-1:0] y);
    char_item_t it;
    it.ch = c;
    it.x  = x;
    it.y  = y;
    pending_chars.push_back(it);
    stim_items++;
  endtask

  // Cursor x clusters around the cell width so backspace hits the left edge.
  function automatic logic [COORD_BITS-1:0] rand_x();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 65535));
      1:       v = int'(stim_cw) - 2 + int'($urandom_range(0, 4));
      2:       v = int'($urandom_range(0, 300));
      default: v = 65535 - int'($urandom_range(0, 2));
    endcase
    if (v < 0) v = 0;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic push_char(input logic [7:0] c);
    push_at(c, rand_x(), COORD_BITS'($urandom_range(0, 65535)));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    push_text(s);
  endtask

  task automatic push_random_burst();
    int kind;
    int n;
    int r;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      push_char(CH_ESC);
      push_char(CH_LBRK);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) push_char(CH_SEMI);
        case ($urandom_range(0, 3))
          0, 1: begin
            r = $urandom_range(0, 16);
            if (r < 7) push_number(30 + r);
            else if (r < 14) push_number(83 + r);
            else if (r == 14) push_number(0);
            else if (r == 15) push_number(37);
            else push_number(97);
          end
          2: push_number($urandom_range(0, 999));
          default: ;
        endcase
      end
      if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(0, 255)));
      else push_char(CH_M);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_char(8'($urandom_range(32, 126)));
    end else if (kind < 60) begin
      push_char(CH_BS);
    end else if (kind < 70) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LBRK);
      push_char(CH_ESC);
      push_char(b);
    end else begin
      push_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits until every byte is taken and every command has come back, and
  // reports any commands that never arrive.
  task automatic wait_idle();
    int n;
    while (pending_chars.size() > 0 || in_valid) @(negedge clk);
    n = 0;
    while (screen_cmds_due.size() > 0 && n < 1000) begin
      @(negedge clk);
      n++;
    end
    if (screen_cmds_due.size() > 0) begin
      report_mismatch("result words never delivered", screen_cmds_due.size(), 0);
      screen_cmds_due.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int target;
    logic [7:0] new_w;
    logic [7:0] new_h;
    logic [31:0] new_bg;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset settings.
    push_at("A", '0, '0);
    push_at(8'h00, '1, '1);
    push_at(8'hFF, 16'h5555, 16'hAAAA);
    push_at(CH_BS, 16'd8, 16'd3);
    push_at(CH_BS, 16'd7, 16'd3);
    push_at(CH_BS, '1, '1);
    push_char(CH_ESC);
    push_text("[31mx");
    push_char(CH_ESC);
    push_text("[96;999my");
    push_char(CH_ESC);
    push_text("Q");
    push_char(CH_ESC);
    push_text("[qk");
    wait_idle();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: begin
          new_w = 8'd1;
          new_h = 8'd1;
          new_bg = 32'h0000_0000;
        end
        2: begin
          new_w = 8'd255;
          new_h = 8'd255;
          new_bg = 32'hFFFF_FFFF;
        end
        3: begin
          // A zero width erases at the cursor itself.
          new_w = 8'd0;
          new_h = 8'($urandom_range(1, 255));
          new_bg = $urandom;
        end
        default: begin
          new_w = 8'($urandom_range(1, 255));
          new_h = 8'($urandom_range(1, 255));
          new_bg = $urandom;
        end
      endcase
      write_reg(REG_CELL_WIDTH, {24'd0, new_w});
      write_reg(REG_CELL_HEIGHT, {24'd0, new_h});
      write_reg(REG_BG_COLOR, new_bg);
      @(negedge clk) cfg_valid <= 1'b0;
      stim_cw = new_w;
      @(posedge clk);
      target = stim_items + 200;
      while (stim_items < target) push_random_burst();
      wait_idle();
    end

    if (err_count == 0)
      $display("ansi_color_escape_parser_unit test passed");
    else
      $display("ansi_color_escape_parser_unit test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ansi_color_escape_parser_unit test failed");
    $finish;
  end

endmodule

FILE: ansi_color_escape_parser_unit.f
hw/rtl/ansi_pkg.sv
hw/rtl/ansi_color_escape_parser_unit.sv
test/testbench.sv
